// ===== design/odo_pkg.sv =====
// shared widths, register codes, sequencer states and divider request type for the odometry block
package odo_pkg;

  localparam int CountW   = 32;
  localparam int PowW     = 8;
  localparam int TickW    = 20;
  localparam int AccW     = 48;
  localparam int TurnW    = 16;
  localparam int CoefW    = 32;
  localparam int WinW     = 16;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  // turn ratio divider: |power difference| * 100 over |larger power|
  localparam int DivNumW = 15;
  localparam int DivDenW = 8;

  // wheel travel multiply: 33-bit magnitude split into two halves
  localparam int MagW   = 33;
  localparam int MulLoW = 17;
  localparam int MulHiW = MagW - MulLoW;
  localparam int ProdW  = MagW + CoefW;

  localparam logic [CoefW-1:0] MM_PER_COUNT_RST = 32'd57191;
  localparam logic [CoefW-1:0] DEG_PER_DIFF_RST = 32'd22599;
  localparam logic [TickW-1:0] TICK_LIMIT_RST   = 20'd480000;
  localparam logic [WinW-1:0]  SPEED_WINDOW_RST = 16'd20;

  localparam logic [CfgIdxW-1:0] CFG_MM_PER_COUNT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEG_PER_DIFF = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_TICK_LIMIT   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_WINDOW = 8'd3;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_SPD,
    ST_FIN
  } odo_state_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

endpackage

// ===== design/odo_if.sv =====
// valid/ready channel interfaces for input words, result words and register writes
interface odo_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [odo_pkg::CountW-1:0]  left_count;
  logic signed [odo_pkg::CountW-1:0]  right_count;
  logic signed [odo_pkg::PowW-1:0]    left_power;
  logic signed [odo_pkg::PowW-1:0]    right_power;

  modport source (output valid, kind, left_count, right_count, left_power, right_power,
                  input ready);
  modport sink   (input valid, kind, left_count, right_count, left_power, right_power,
                  output ready);
endinterface

interface odo_out_if;
  logic                               valid;
  logic                               ready;
  logic        [odo_pkg::TickW-1:0]   elapsed_ticks;
  logic signed [odo_pkg::AccW-1:0]    distance_q16;
  logic signed [odo_pkg::AccW-1:0]    heading_q16;
  logic signed [odo_pkg::AccW-1:0]    speed_q16;
  logic signed [odo_pkg::CountW-1:0]  left_delta;
  logic signed [odo_pkg::CountW-1:0]  right_delta;
  logic signed [odo_pkg::PowW-1:0]    drive_power;
  logic signed [odo_pkg::TurnW-1:0]   turn_ratio;

  modport source (output valid, elapsed_ticks, distance_q16, heading_q16, speed_q16,
                  left_delta, right_delta, drive_power, turn_ratio, input ready);
  modport sink   (input valid, elapsed_ticks, distance_q16, heading_q16, speed_q16,
                  left_delta, right_delta, drive_power, turn_ratio, output ready);
endinterface

interface odo_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [odo_pkg::CfgIdxW-1:0]     index;
  logic [odo_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/odo_div.sv =====
// iterative restoring divider, one quotient bit per cycle, for the turn ratio
module odo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  odo_pkg::div_req_t           req,
  output logic                        busy,
  output logic [odo_pkg::DivNumW-1:0] quot
);

  localparam int NumW = odo_pkg::DivNumW;
  localparam int DenW = odo_pkg::DivDenW;
  localparam int CntW = $clog2(NumW);

  logic            busy_r;
  logic [CntW-1:0] cnt_r;
  logic [DenW-1:0] rem_r;
  logic [DenW-1:0] den_r;
  logic [NumW-1:0] quo_r;

  logic [DenW:0]   trial;
  logic            fits;
  logic [DenW:0]   trial_sub;

  assign trial     = {rem_r, quo_r[NumW-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CntW'(NumW - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[DenW-1:0] : trial[DenW-1:0];
      quo_r <= {quo_r[NumW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

// ===== design/differential_wheel_odometry.sv =====
// top level of the differential-drive wheel odometry block
// One input word is taken at a time. A tick word runs through a short sequencer that uses one
// shared 17 x 32 multiplier four times (low and high halves of the wheel-sum magnitude times
// mm_per_count, then of the wheel-difference magnitude times deg_per_diff), adds each
// scaled increment into its saturating 48-bit accumulator and then checks the speed window.
// The turn ratio comes from a restoring divider that starts when the word is accepted and
// delivers one quotient bit per cycle; its 15 steps set the pace. The result word is loaded
// into the output register from the finishing step once the divider is done, tick and restart
// alike, and the next word can be accepted the cycle after the load. The result sits in an
// output register, so the next word is taken while an earlier result still waits on
// out_ch.ready; a word that finishes while that register is still full holds in its last
// step, with the input not ready, until out_ch.ready frees the register.
// Register writes are always accepted (cfg_ch.ready is tied high) and are meant to arrive only
// while the block is idle; indexes past the last register are ignored.
module differential_wheel_odometry (
  input  logic      clk,
  input  logic      rst_n,
  odo_in_if.sink    in_ch,
  odo_out_if.source out_ch,
  odo_cfg_if.sink   cfg_ch
);

  localparam int CountW = odo_pkg::CountW;
  localparam int PowW   = odo_pkg::PowW;
  localparam int TickW  = odo_pkg::TickW;
  localparam int AccW   = odo_pkg::AccW;
  localparam int TurnW  = odo_pkg::TurnW;
  localparam int CoefW  = odo_pkg::CoefW;
  localparam int WinW   = odo_pkg::WinW;
  localparam int MagW   = odo_pkg::MagW;
  localparam int MulLoW = odo_pkg::MulLoW;
  localparam int ProdW  = odo_pkg::ProdW;
  localparam int NumW   = odo_pkg::DivNumW;
  localparam int DenW   = odo_pkg::DivDenW;
  localparam int MpW    = MulLoW + CoefW;

  localparam logic signed [AccW:0] SAT_HI = {2'b00, {(AccW-1){1'b1}}};
  localparam logic signed [AccW:0] SAT_LO = {2'b11, {(AccW-1){1'b0}}};
  localparam logic [ProdW-1:0]     MAG_CAP = ProdW'(1) << (AccW - 1);

  // clamp a 49-bit signed value into the signed 48-bit range
  function automatic logic [AccW-1:0] clamp48(input logic signed [AccW:0] v);
    logic [AccW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[AccW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[AccW-1:0];
    end else begin
      res = v[AccW-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [CoefW-1:0] mm_per_count_r;
  logic [CoefW-1:0] deg_per_diff_r;
  logic [TickW-1:0] tick_limit_r;
  logic [WinW-1:0]  speed_window_r;

  // odometry state
  logic [CountW-1:0] prev_left_r;
  logic [CountW-1:0] prev_right_r;
  logic [TickW-1:0]  tick_r;
  logic [AccW-1:0]   dist_r;
  logic [AccW-1:0]   head_r;
  logic [AccW-1:0]   speed_r;
  logic [TickW-1:0]  wst_r;
  logic [AccW-1:0]   wsd_r;

  // per-word working registers
  logic [CountW-1:0] dl_r;
  logic [CountW-1:0] dr_r;
  logic [MagW-1:0]   mag_s_r;
  logic [MagW-1:0]   mag_d_r;
  logic              neg_s_r;
  logic              neg_d_r;
  logic              sel_h_r;
  logic [ProdW-1:0]  prod_r;
  logic [PowW-1:0]   pw_r;
  logic              tneg_r;
  logic              pzero_r;

  // sequencer
  odo_pkg::odo_state_t state_r, state_nxt;
  logic in_ready;
  logic in_acc;
  logic out_load;

  // output register
  logic              out_valid_r;
  logic [TickW-1:0]  out_tick_r;
  logic [AccW-1:0]   out_dist_r;
  logic [AccW-1:0]   out_head_r;
  logic [AccW-1:0]   out_speed_r;
  logic [CountW-1:0] out_dl_r;
  logic [CountW-1:0] out_dr_r;
  logic [PowW-1:0]   out_pw_r;
  logic [TurnW-1:0]  out_turn_r;

  // divider
  odo_pkg::div_req_t div_req;
  logic              div_busy;
  logic [NumW-1:0]   div_quot;

  // power compare, done on the incoming word
  logic signed [PowW:0] pdiff;
  logic [PowW-1:0]      pw_sel;
  logic [PowW:0]        pdiff_abs;
  logic [PowW:0]        pw_abs;
  logic                 tneg;

  // wheel sum and difference
  logic signed [MagW:0] wsum;
  logic signed [MagW:0] wdif;
  logic [MagW:0]        wsum_abs;
  logic [MagW:0]        wdif_abs;

  // shared multiplier
  logic [MagW-1:0]   mag_sel;
  logic [CoefW-1:0]  coef_sel;
  logic [MulLoW-1:0] mul_a;
  logic [MpW-1:0]    mp;

  // accumulate step
  logic [ProdW-1:0]      scaled;
  logic [AccW-1:0]       mag_cap;
  logic signed [AccW:0]  inc_raw;
  logic [AccW-1:0]       inc;
  logic signed [AccW:0]  acc_sum;
  logic [AccW-1:0]       acc_sel;

  // speed window
  logic [TickW-1:0]     span;
  logic signed [AccW:0] speed_diff;

  logic [TurnW-1:0] turn_val;

  assign in_acc = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // larger power wins, left on a tie; turn is negative when the sign of the larger power
  // disagrees with the direction of the difference
  always_comb begin
    pdiff     = {in_ch.left_power[PowW-1], in_ch.left_power}
              - {in_ch.right_power[PowW-1], in_ch.right_power};
    pw_sel    = (pdiff >= 0) ? in_ch.left_power : in_ch.right_power;
    pdiff_abs = pdiff[PowW] ? (PowW+1)'(-pdiff) : pdiff;
    pw_abs    = pw_sel[PowW-1] ? (PowW+1)'(-{1'b1, pw_sel}) : {1'b0, pw_sel};
    tneg      = (pdiff > 0) ? pw_sel[PowW-1] : (!pw_sel[PowW-1] && (pw_sel != '0));
  end

  always_comb begin
    div_req.start = in_acc;
    div_req.num   = NumW'(pdiff_abs[PowW-1:0]) * NumW'(100);
    div_req.den   = pw_abs[DenW-1:0];
  end

  odo_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .busy (div_busy),
    .quot (div_quot)
  );

  // sign-extended sum and difference of the wheel deltas
  always_comb begin
    wsum     = (MagW+1)'($signed(dl_r)) + (MagW+1)'($signed(dr_r));
    wdif     = (MagW+1)'($signed(dl_r)) - (MagW+1)'($signed(dr_r));
    wsum_abs = wsum[MagW] ? (MagW+1)'(-wsum) : wsum;
    wdif_abs = wdif[MagW] ? (MagW+1)'(-wdif) : wdif;
  end

  // shared multiplier, low half then high half of the selected magnitude
  always_comb begin
    mag_sel  = sel_h_r ? mag_d_r : mag_s_r;
    coef_sel = sel_h_r ? deg_per_diff_r : mm_per_count_r;
    mul_a    = (state_r == odo_pkg::ST_MHI) ? MulLoW'(mag_sel[MagW-1:MulLoW])
                                            : mag_sel[MulLoW-1:0];
    mp       = MpW'(mul_a) * MpW'(coef_sel);
  end

  // distance halves the product; magnitude capped at 2^47 before the sign goes back on
  always_comb begin
    scaled  = sel_h_r ? prod_r : (prod_r >> 1);
    mag_cap = (scaled > MAG_CAP) ? MAG_CAP[AccW-1:0] : scaled[AccW-1:0];
    inc_raw = (sel_h_r ? neg_d_r : neg_s_r) ? -$signed({1'b0, mag_cap})
                                             : $signed({1'b0, mag_cap});
    inc     = clamp48(inc_raw);
    acc_sel = sel_h_r ? head_r : dist_r;
    acc_sum = $signed({acc_sel[AccW-1], acc_sel}) + $signed({inc[AccW-1], inc});
  end

  always_comb begin
    span       = tick_r - wst_r;
    speed_diff = $signed({dist_r[AccW-1], dist_r}) - $signed({wsd_r[AccW-1], wsd_r});
  end

  always_comb begin
    if (pzero_r) begin
      turn_val = '0;
    end else if (tneg_r) begin
      turn_val = TurnW'(-{1'b0, div_quot});
    end else begin
      turn_val = TurnW'(div_quot);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= odo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      odo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = (in_ch.kind == odo_pkg::KIND_RESTART) ? odo_pkg::ST_FIN
                                                            : odo_pkg::ST_PREP;
        end
      end
      odo_pkg::ST_PREP: state_nxt = odo_pkg::ST_MLO;
      odo_pkg::ST_MLO:  state_nxt = odo_pkg::ST_MHI;
      odo_pkg::ST_MHI:  state_nxt = odo_pkg::ST_ACC;
      odo_pkg::ST_ACC:  state_nxt = sel_h_r ? odo_pkg::ST_SPD : odo_pkg::ST_MLO;
      odo_pkg::ST_SPD:  state_nxt = odo_pkg::ST_FIN;
      odo_pkg::ST_FIN: begin
        // wait for the divider and a free output register
        if (!div_busy && (!out_valid_r || out_ch.ready)) begin
          out_load  = 1'b1;
          state_nxt = odo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_per_count_r <= odo_pkg::MM_PER_COUNT_RST;
      deg_per_diff_r <= odo_pkg::DEG_PER_DIFF_RST;
      tick_limit_r   <= odo_pkg::TICK_LIMIT_RST;
      speed_window_r <= odo_pkg::SPEED_WINDOW_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        odo_pkg::CFG_MM_PER_COUNT: mm_per_count_r <= cfg_ch.data;
        odo_pkg::CFG_DEG_PER_DIFF: deg_per_diff_r <= cfg_ch.data;
        odo_pkg::CFG_TICK_LIMIT:   tick_limit_r   <= cfg_ch.data[TickW-1:0];
        odo_pkg::CFG_SPEED_WINDOW: speed_window_r <= cfg_ch.data[WinW-1:0];
        default: ;
      endcase
    end
  end

  // odometry state: baseline, tick count, accumulators and speed window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
      tick_r       <= '0;
      dist_r       <= '0;
      head_r       <= '0;
      speed_r      <= '0;
      wst_r        <= '0;
      wsd_r        <= '0;
    end else begin
      if (in_acc) begin
        prev_left_r  <= in_ch.left_count;
        prev_right_r <= in_ch.right_count;
        if (in_ch.kind == odo_pkg::KIND_RESTART) begin
          tick_r  <= '0;
          dist_r  <= '0;
          head_r  <= '0;
          speed_r <= '0;
          wst_r   <= '0;
          wsd_r   <= '0;
        end else if (tick_r < tick_limit_r) begin
          tick_r <= tick_r + 1'b1;
        end
      end
      if (state_r == odo_pkg::ST_ACC) begin
        if (sel_h_r) begin
          head_r <= clamp48(acc_sum);
        end else begin
          dist_r <= clamp48(acc_sum);
        end
      end
      if (state_r == odo_pkg::ST_SPD && span >= TickW'(speed_window_r)) begin
        speed_r <= clamp48(speed_diff);
        wst_r   <= tick_r;
        wsd_r   <= dist_r;
      end
    end
  end

  // per-word datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_ch.kind == odo_pkg::KIND_RESTART) begin
        dl_r <= '0;
        dr_r <= '0;
      end else begin
        dl_r <= in_ch.left_count - prev_left_r;
        dr_r <= in_ch.right_count - prev_right_r;
      end
      pw_r    <= pw_sel;
      tneg_r  <= tneg;
      pzero_r <= (pw_sel == '0);
      sel_h_r <= 1'b0;
    end
    if (state_r == odo_pkg::ST_PREP) begin
      mag_s_r <= wsum_abs[MagW-1:0];
      mag_d_r <= wdif_abs[MagW-1:0];
      neg_s_r <= wsum[MagW];
      neg_d_r <= wdif[MagW];
    end
    if (state_r == odo_pkg::ST_MLO) begin
      prod_r <= ProdW'(mp);
    end
    if (state_r == odo_pkg::ST_MHI) begin
      prod_r <= prod_r + (ProdW'(mp) << MulLoW);
    end
    if (state_r == odo_pkg::ST_ACC) begin
      sel_h_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tick_r  <= tick_r;
      out_dist_r  <= dist_r;
      out_head_r  <= head_r;
      out_speed_r <= speed_r;
      out_dl_r    <= dl_r;
      out_dr_r    <= dr_r;
      out_pw_r    <= pw_r;
      out_turn_r  <= turn_val;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.elapsed_ticks = out_tick_r;
  assign out_ch.distance_q16  = out_dist_r;
  assign out_ch.heading_q16   = out_head_r;
  assign out_ch.speed_q16     = out_speed_r;
  assign out_ch.left_delta    = out_dl_r;
  assign out_ch.right_delta   = out_dr_r;
  assign out_ch.drive_power   = out_pw_r;
  assign out_ch.turn_ratio    = out_turn_r;

  // a word in flight blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready while a word is in flight");

  // a result only appears from the finishing step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == odo_pkg::ST_FIN))
    else $error("result word raised outside the finishing step");

  // a restart clears the counter and accumulators
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == odo_pkg::KIND_RESTART) |=>
      (tick_r == '0 && dist_r == '0 && head_r == '0 && speed_r == '0))
    else $error("restart left odometry state uncleared");

  // the result is never loaded while the divider still iterates
  a_div_done_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(!div_busy))
    else $error("result loaded before the turn ratio was ready");

endmodule

// ===== tb/tb_differential_wheel_odometry.sv =====
// self-checking testbench for the differential wheel odometry block, with its own predictor
module tb_differential_wheel_odometry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CountW   = odo_pkg::CountW;
  localparam int PowW     = odo_pkg::PowW;
  localparam int TickW    = odo_pkg::TickW;
  localparam int AccW     = odo_pkg::AccW;
  localparam int TurnW    = odo_pkg::TurnW;
  localparam int CoefW    = odo_pkg::CoefW;
  localparam int WinW     = odo_pkg::WinW;
  localparam int CfgIdxW  = odo_pkg::CfgIdxW;
  localparam int CfgDataW = odo_pkg::CfgDataW;

  // settling time for the block before register writes
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINTS    = 40;

  // signed 48-bit saturation bounds, held in 64-bit arithmetic
  localparam longint          ACC_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam longint          ACC_MIN = -(64'sd1 <<< 47);
  localparam longint unsigned MAG_CAP = 64'd1 << 47;

  // one input word as the testbench builds it
  typedef struct {
    logic                     kind;
    logic signed [CountW-1:0] left_count;
    logic signed [CountW-1:0] right_count;
    logic signed [PowW-1:0]   left_power;
    logic signed [PowW-1:0]   right_power;
  } odo_word_t;

  // one result word, field for field as out_ch carries it
  typedef struct {
    logic        [TickW-1:0]  elapsed_ticks;
    logic signed [AccW-1:0]   distance_q16;
    logic signed [AccW-1:0]   heading_q16;
    logic signed [AccW-1:0]   speed_q16;
    logic signed [CountW-1:0] left_delta;
    logic signed [CountW-1:0] right_delta;
    logic signed [PowW-1:0]   drive_power;
    logic signed [TurnW-1:0]  turn_ratio;
  } odo_result_t;

  logic clk;
  logic rst_n;

  odo_in_if  in_ch ();
  odo_out_if out_ch ();
  odo_cfg_if cfg_ch ();

  differential_wheel_odometry dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // register shadows, as the block should hold them
  logic [CoefW-1:0] mm_per_count_sh;
  logic [CoefW-1:0] deg_per_diff_sh;
  logic [TickW-1:0] tick_limit_sh;
  logic [WinW-1:0]  speed_window_sh;

  // odometry state mirrored by the predictor
  logic [CountW-1:0] last_left;
  logic [CountW-1:0] last_right;
  logic [TickW-1:0]  tick_total;
  logic [TickW-1:0]  window_tick;
  longint            dist_total;
  longint            heading_total;
  longint            speed_sample;
  longint            window_dist;

  // results still owed by the block, oldest first
  odo_result_t expected_results[$];

  // last encoder positions sent, so random motion continues from them
  logic signed [CountW-1:0] wheel_left;
  logic signed [CountW-1:0] wheel_right;

  // idling controls shared between the sequence and the two channel sides
  bit in_idle      = 1'b1;
  bit out_idle     = 1'b1;
  int hold_request = 0;

  int mismatch_count  = 0;
  int results_checked = 0;
  int words_sent      = 0;
  int restarts_sent   = 0;
  int reg_writes      = 0;
  int settings_used   = 0;

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  task automatic clear_odometry_state();
    mm_per_count_sh = odo_pkg::MM_PER_COUNT_RST;
    deg_per_diff_sh = odo_pkg::DEG_PER_DIFF_RST;
    tick_limit_sh   = odo_pkg::TICK_LIMIT_RST;
    speed_window_sh = odo_pkg::SPEED_WINDOW_RST;
    last_left       = '0;
    last_right      = '0;
    tick_total      = '0;
    window_tick     = '0;
    dist_total      = 0;
    heading_total   = 0;
    speed_sample    = 0;
    window_dist     = 0;
  endtask

  function automatic longint sat48(longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // count delta times an unsigned Q16 coefficient, magnitude capped at 2^47, then saturated
  function automatic longint scale_travel(longint d, logic [CoefW-1:0] coef, bit halve);
    longint unsigned mag;
    bit              neg;
    neg = d < 0;
    mag = neg ? -d : d;
    mag = mag * {32'd0, coef};
    if (halve) mag = mag >> 1;
    if (mag > MAG_CAP) mag = MAG_CAP;
    return sat48(neg ? -longint'(mag) : longint'(mag));
  endfunction

  // larger power and the percent difference over it; a zero divisor gives zero
  function automatic void drive_and_turn(input logic signed [PowW-1:0] lp,
                                         input logic signed [PowW-1:0] rp,
                                         output logic signed [PowW-1:0] pw,
                                         output logic signed [TurnW-1:0] turn);
    int l;
    int r;
    int t;
    l = lp;
    r = rp;
    if (l == r) begin
      pw = lp;
      t  = 0;
    end else if (l > r) begin
      pw = lp;
      t  = (l == 0) ? 0 : ((l - r) * 100) / l;
    end else begin
      pw = rp;
      t  = (r == 0) ? 0 : -(((r - l) * 100) / r);
    end
    turn = t[TurnW-1:0];
  endfunction

  function automatic odo_result_t predict_odometry(odo_word_t w);
    odo_result_t              res;
    logic signed [CountW-1:0] dl32;
    logic signed [CountW-1:0] dr32;
    longint                   dl;
    longint                   dr;
    logic [TickW-1:0]         span;
    dl = 0;
    dr = 0;
    drive_and_turn(w.left_power, w.right_power, res.drive_power, res.turn_ratio);
    if (w.kind == odo_pkg::KIND_RESTART) begin
      // new baseline, everything else starts over
      last_left     = w.left_count;
      last_right    = w.right_count;
      tick_total    = '0;
      window_tick   = '0;
      dist_total    = 0;
      heading_total = 0;
      speed_sample  = 0;
      window_dist   = 0;
    end else begin
      if (tick_total < tick_limit_sh) tick_total = tick_total + 1'b1;
      // wrapped 32-bit differences
      dl32 = w.left_count - last_left;
      dr32 = w.right_count - last_right;
      dl   = dl32;
      dr   = dr32;
      last_left  = w.left_count;
      last_right = w.right_count;
      dist_total    = sat48(dist_total + scale_travel(dl + dr, mm_per_count_sh, 1'b1));
      heading_total = sat48(heading_total + scale_travel(dl - dr, deg_per_diff_sh, 1'b0));
      span = tick_total - window_tick;
      if (span >= speed_window_sh) begin
        speed_sample = sat48(dist_total - window_dist);
        window_tick  = tick_total;
        window_dist  = dist_total;
      end
    end
    res.elapsed_ticks = tick_total;
    res.distance_q16  = dist_total[AccW-1:0];
    res.heading_q16   = heading_total[AccW-1:0];
    res.speed_q16     = speed_sample[AccW-1:0];
    res.left_delta    = dl[CountW-1:0];
    res.right_delta   = dr[CountW-1:0];
    return res;
  endfunction

  // ------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // every accepted result word is compared with the oldest expectation
  always @(posedge clk) begin : result_checker
    odo_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected", 0, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_ch.elapsed_ticks !== want.elapsed_ticks)
          report_mismatch("elapsed_ticks", out_ch.elapsed_ticks, want.elapsed_ticks);
        if (out_ch.distance_q16 !== want.distance_q16)
          report_mismatch("distance_q16", out_ch.distance_q16, want.distance_q16);
        if (out_ch.heading_q16 !== want.heading_q16)
          report_mismatch("heading_q16", out_ch.heading_q16, want.heading_q16);
        if (out_ch.speed_q16 !== want.speed_q16)
          report_mismatch("speed_q16", out_ch.speed_q16, want.speed_q16);
        if (out_ch.left_delta !== want.left_delta)
          report_mismatch("left_delta", out_ch.left_delta, want.left_delta);
        if (out_ch.right_delta !== want.right_delta)
          report_mismatch("right_delta", out_ch.right_delta, want.right_delta);
        if (out_ch.drive_power !== want.drive_power)
          report_mismatch("drive_power", out_ch.drive_power, want.drive_power);
        if (out_ch.turn_ratio !== want.turn_ratio)
          report_mismatch("turn_ratio", out_ch.turn_ratio, want.turn_ratio);
      end
    end
  end

  // ------------------------------------------------------------------
  // result side: ready in random runs, stall bursts, and a long hold-off on request
  // ------------------------------------------------------------------

  initial begin : result_receiver
    int n;
    forever begin
      if (hold_request > 0) begin
        // long hold-off, counted here so the sender keeps pushing words meanwhile
        n = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < n; c++) @(posedge clk);
      end else if (out_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------

  function automatic odo_word_t make_word(logic kind, logic signed [CountW-1:0] l,
                                          logic signed [CountW-1:0] r,
                                          logic signed [PowW-1:0] lp,
                                          logic signed [PowW-1:0] rp);
    odo_word_t w;
    w.kind        = kind;
    w.left_count  = l;
    w.right_count = r;
    w.left_power  = lp;
    w.right_power = rp;
    return w;
  endfunction

  // offers one word, maybe after a gap, and books its expected result on acceptance
  task automatic send_word(odo_word_t w);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= w.kind;
    in_ch.left_count  <= w.left_count;
    in_ch.right_count <= w.right_count;
    in_ch.left_power  <= w.left_power;
    in_ch.right_power <= w.right_power;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_odometry(w));
    wheel_left  = w.left_count;
    wheel_right = w.right_count;
    words_sent++;
    if (w.kind == odo_pkg::KIND_RESTART) restarts_sent++;
  endtask

  // stop offering, let every owed result arrive, then give the block time to go quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four registers, then one index past the last that must be ignored
  task automatic set_config(logic [CfgDataW-1:0] mm, logic [CfgDataW-1:0] deg,
                            logic [CfgDataW-1:0] limit, logic [CfgDataW-1:0] window);
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: begin
          idx  = odo_pkg::CFG_MM_PER_COUNT;
          data = mm;
        end
        1: begin
          idx  = odo_pkg::CFG_DEG_PER_DIFF;
          data = deg;
        end
        2: begin
          idx  = odo_pkg::CFG_TICK_LIMIT;
          data = {12'($urandom), limit[TickW-1:0]};
        end
        3: begin
          idx  = odo_pkg::CFG_SPEED_WINDOW;
          data = {16'($urandom), window[WinW-1:0]};
        end
        default: begin
          idx  = CfgIdxW'($urandom_range(int'(odo_pkg::CFG_SPEED_WINDOW) + 1, 255));
          data = $urandom;
        end
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= data;
      do @(posedge clk); while (!cfg_ch.ready);
      reg_writes++;
      case (idx)
        odo_pkg::CFG_MM_PER_COUNT: mm_per_count_sh = data;
        odo_pkg::CFG_DEG_PER_DIFF: deg_per_diff_sh = data;
        odo_pkg::CFG_TICK_LIMIT:   tick_limit_sh   = data[TickW-1:0];
        odo_pkg::CFG_SPEED_WINDOW: speed_window_sh = data[WinW-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // mostly small wheel motion, sometimes large jumps, rarely an arbitrary position
  function automatic logic signed [CountW-1:0] move_wheel(logic signed [CountW-1:0] pos);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return pos + (int'($urandom_range(0, 6000)) - 3000);
    if (pick < 95) return pos + (int'($urandom_range(0, 1 << 21)) - (1 << 20));
    return $urandom;
  endfunction

  // powers mostly within the percent range, sometimes any 8-bit value
  function automatic logic signed [PowW-1:0] pick_power();
    int p;
    if ($urandom_range(0, 9) != 0) begin
      p = int'($urandom_range(0, 200)) - 100;
      return p[PowW-1:0];
    end
    return PowW'($urandom);
  endfunction

  // a run of ticks with the occasional restart; wild makes every position arbitrary
  task automatic send_random_words(int count, bit wild);
    odo_word_t w;
    logic signed [CountW-1:0] l;
    logic signed [CountW-1:0] r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 79) == 0) begin
        w.kind = odo_pkg::KIND_RESTART;
        l = $urandom;
        r = $urandom;
      end else begin
        w.kind = odo_pkg::KIND_TICK;
        l = wild ? $urandom : move_wheel(wheel_left);
        r = wild ? $urandom : move_wheel(wheel_right);
      end
      w.left_count  = l;
      w.right_count = r;
      w.left_power  = pick_power();
      w.right_power = ($urandom_range(0, 9) == 0) ? w.left_power : pick_power();
      send_word(w);
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset registers: power extremes, zero divisors, equal powers, wrapped counts
  task automatic test_directed_basics();
    send_word(make_word(odo_pkg::KIND_RESTART, 0, 0, 0, 0));
    send_word(make_word(odo_pkg::KIND_TICK, 100, 50, 50, 50));
    send_word(make_word(odo_pkg::KIND_TICK, -100, 300, 100, -100));
    send_word(make_word(odo_pkg::KIND_TICK, -100, 300, -100, 100));
    // larger power is zero on either side
    send_word(make_word(odo_pkg::KIND_TICK, 400, -200, 0, -50));
    send_word(make_word(odo_pkg::KIND_TICK, 400, -200, -50, 0));
    // full 8-bit powers
    send_word(make_word(odo_pkg::KIND_TICK, 1000, 1000, 8'sh80, 8'sh7F));
    send_word(make_word(odo_pkg::KIND_TICK, 2000, 1500, 8'sh7F, 8'sh80));
    send_word(make_word(odo_pkg::KIND_TICK, 2000, 1500, 8'sh80, 8'sh80));
    send_word(make_word(odo_pkg::KIND_TICK, 2100, 1400, 8'shFF, 8'sh80));
    send_word(make_word(odo_pkg::KIND_TICK, 2200, 1300, 8'sh80, 8'shFF));
    // baseline near the wrap point, then ticks that cross it
    send_word(make_word(odo_pkg::KIND_RESTART, 32'sh7FFF_FFF0, 32'sh8000_0010, 100, 100));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh8000_0005, 32'sh7FFF_FFF5, 60, 40));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, -60, -40));
    send_word(make_word(odo_pkg::KIND_RESTART, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, 100, 100));
    send_word(make_word(odo_pkg::KIND_TICK, 32'shFFFF_FFFF, 32'sh0000_0000, -100, -100));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh0000_0000, 32'shFFFF_FFFF, 1, -1));
  endtask

  // register extremes: saturation, tick limit zero and lowered, speed window zero
  task automatic test_register_extremes();
    // largest coefficients, counter pinned at zero, speed sampled every tick
    wait_idle();
    set_config('1, '1, 0, 0);
    send_word(make_word(odo_pkg::KIND_RESTART, 0, 0, 20, 10));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20, 10));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20, 10));
    send_word(make_word(odo_pkg::KIND_TICK, 0, 0, 20, 10));
    send_word(make_word(odo_pkg::KIND_TICK, 32'sh8000_0001, 32'sh8000_0001, 20, 10));
    send_random_words(12, 1'b1);

    // zero coefficients, limit and window of one
    wait_idle();
    set_config(0, 0, 1, 1);
    send_random_words(10, 1'b0);

    // unit coefficients, largest limit and window
    wait_idle();
    set_config(1, 1, 20'hF_FFFF, 16'hFFFF);
    send_word(make_word(odo_pkg::KIND_RESTART, wheel_left, wheel_right, 0, 0));
    send_random_words(10, 1'b0);

    // counter saturates at a small limit, then the limit drops below the count
    wait_idle();
    set_config(odo_pkg::MM_PER_COUNT_RST, odo_pkg::DEG_PER_DIFF_RST, 5, 3);
    send_word(make_word(odo_pkg::KIND_RESTART, wheel_left, wheel_right, 30, 30));
    send_random_words(9, 1'b0);
    wait_idle();
    set_config(odo_pkg::MM_PER_COUNT_RST, odo_pkg::DEG_PER_DIFF_RST, 2, 3);
    send_random_words(5, 1'b0);
  endtask

  // six register settings, each with a long stream of motion, mostly smooth save the last
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase % 4)
        0: set_config(odo_pkg::MM_PER_COUNT_RST, odo_pkg::DEG_PER_DIFF_RST,
                      odo_pkg::TICK_LIMIT_RST, odo_pkg::SPEED_WINDOW_RST);
        1: set_config($urandom, $urandom, $urandom_range(1, 1048575), $urandom_range(1, 64));
        2: set_config($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                      $urandom_range(0, 40), $urandom_range(0, 30));
        default: set_config($urandom | 32'hC000_0000, $urandom | 32'hC000_0000,
                            $urandom_range(100, 2000), $urandom_range(1, 100));
      endcase
      send_random_words(250, phase == 5);
    end
  endtask

  // receiver stops for a long stretch while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_idle();
    set_config(odo_pkg::MM_PER_COUNT_RST, odo_pkg::DEG_PER_DIFF_RST,
               odo_pkg::TICK_LIMIT_RST, 4);
    in_idle = 1'b0;
    hold_request = 300;
    send_random_words(30, 1'b0);
    in_idle = 1'b1;
  endtask

  // back-to-back words with both sides always ready
  task automatic test_steady_stream();
    wait_idle();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_random_words(200, 1'b0);
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------

  initial begin : main_sequence
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= odo_pkg::KIND_TICK;
    in_ch.left_count  <= '0;
    in_ch.right_count <= '0;
    in_ch.left_power  <= '0;
    in_ch.right_power <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= odo_pkg::CFG_MM_PER_COUNT;
    cfg_ch.data       <= '0;
    wheel_left  = '0;
    wheel_right = '0;
    clear_odometry_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    test_steady_stream();
    wait_idle();

    $display("summary: %0d input words (%0d restarts) gave %0d checked result words",
             words_sent, restarts_sent, results_checked);
    $display("summary: %0d register writes over %0d settings, %0d mismatches",
             reg_writes, settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : run_limit
    #1_500_000;
    $display("timeout with %0d result words still owed", expected_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule
